### rtl/adsr_pkg.sv
// Package for the ADSR envelope tick generator: codes, register map,
// configuration struct and small helper functions. No dependencies.
`default_nettype none

package adsr_pkg;

  // Default fraction bits of the volume fixed-point format
  localparam int VOL_FRAC_BITS_DEF = 8;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int VEL_W   = 7;
  localparam int VOL_W   = 15;
  localparam int PHASE_W = 3;
  localparam int LVLR_W  = 7;
  localparam int RATE_W  = 6;
  localparam int TICKS_W = 8;
  localparam int CNT_W   = 8;

  // APB port
  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;

  // Envelope phases
  localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_OFF     = 3'd4;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ATTACK_LEVEL  = 3'd0;
  localparam logic [2:0] REG_DECAY_LEVEL   = 3'd1;
  localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd2;
  localparam logic [2:0] REG_ATTACK_RATE   = 3'd3;
  localparam logic [2:0] REG_DECAY_RATE    = 3'd4;
  localparam logic [2:0] REG_SUSTAIN_TICKS = 3'd5;
  localparam logic [2:0] REG_RELEASE_RATE  = 3'd6;

  // Register reset values
  localparam logic [LVLR_W-1:0]  RST_ATTACK_LEVEL  = 7'd64;
  localparam logic [LVLR_W-1:0]  RST_DECAY_LEVEL   = 7'd48;
  localparam logic [LVLR_W-1:0]  RST_SUSTAIN_LEVEL = 7'd48;
  localparam logic [RATE_W-1:0]  RST_ATTACK_RATE   = 6'd0;
  localparam logic [RATE_W-1:0]  RST_DECAY_RATE    = 6'd0;
  localparam logic [TICKS_W-1:0] RST_SUSTAIN_TICKS = 8'd0;
  localparam logic [RATE_W-1:0]  RST_RELEASE_RATE  = 6'd4;

  // Arithmetic constants
  localparam logic [LVLR_W-1:0] LVL_CAP     = 7'd64;
  localparam logic [VEL_W-1:0]  VEL_DEFAULT = 7'd64;
  localparam logic [CNT_W-1:0]  VEL_DIVISOR = 8'd127;
  localparam logic [VOL_W-1:0]  VOL_MAX     = 15'h7FFF;

  // How the quotient of a division lands in the level
  localparam logic [1:0] LV_QUO = 2'd0;
  localparam logic [1:0] LV_ADD = 2'd1;
  localparam logic [1:0] LV_SUB = 2'd2;

  typedef struct packed {
    logic [LVLR_W-1:0]  attack_level;
    logic [LVLR_W-1:0]  decay_level;
    logic [LVLR_W-1:0]  sustain_level;
    logic [RATE_W-1:0]  attack_rate;
    logic [RATE_W-1:0]  decay_rate;
    logic [TICKS_W-1:0] sustain_ticks;
    logic [RATE_W-1:0]  release_rate;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Ramp length in ticks: rate * 4 + 1
  function automatic logic [CNT_W-1:0] ramp_len(input logic [RATE_W-1:0] rate);
    ramp_len = {rate, 2'b00} + 8'd1;
  endfunction

  // Clamp a level register to the top of the range
  function automatic logic [LVLR_W-1:0] lvl_cap(input logic [LVLR_W-1:0] lvl);
    lvl_cap = (lvl > LVL_CAP) ? LVL_CAP : lvl;
  endfunction

endpackage

`default_nettype wire

### rtl/adsr_cmd_if.sv
// Command channel: valid/ready handshake carrying cmd and velocity.
// Depends on adsr_pkg for field widths.
`default_nettype none

interface adsr_cmd_if
  import adsr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [VEL_W-1:0] velocity;

  modport source (output valid, output cmd, output velocity, input ready);
  modport sink   (input valid, input cmd, input velocity, output ready);
endinterface

`default_nettype wire

### rtl/adsr_rsp_if.sv
// Result channel: valid/ready handshake carrying volume, phase and active.
// Depends on adsr_pkg for field widths.
`default_nettype none

interface adsr_rsp_if
  import adsr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VOL_W-1:0]   volume;
  logic [PHASE_W-1:0] env_phase;
  logic               active;

  modport source (output valid, output volume, output env_phase, output active,
                  input ready);
  modport sink   (input valid, input volume, input env_phase, input active,
                  output ready);
endinterface

`default_nettype wire

### rtl/adsr_regs.sv
// APB configuration registers of the envelope generator.
// Depends on adsr_pkg for the register map and cfg_t.
`default_nettype none

module adsr_regs
  import adsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write a register on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_level  <= RST_ATTACK_LEVEL;
      cfg.decay_level   <= RST_DECAY_LEVEL;
      cfg.sustain_level <= RST_SUSTAIN_LEVEL;
      cfg.attack_rate   <= RST_ATTACK_RATE;
      cfg.decay_rate    <= RST_DECAY_RATE;
      cfg.sustain_ticks <= RST_SUSTAIN_TICKS;
      cfg.release_rate  <= RST_RELEASE_RATE;
    end else if (wr) begin
      case (idx)
        REG_ATTACK_LEVEL:  cfg.attack_level  <= pwdata[LVLR_W-1:0];
        REG_DECAY_LEVEL:   cfg.decay_level   <= pwdata[LVLR_W-1:0];
        REG_SUSTAIN_LEVEL: cfg.sustain_level <= pwdata[LVLR_W-1:0];
        REG_ATTACK_RATE:   cfg.attack_rate   <= pwdata[RATE_W-1:0];
        REG_DECAY_RATE:    cfg.decay_rate    <= pwdata[RATE_W-1:0];
        REG_SUSTAIN_TICKS: cfg.sustain_ticks <= pwdata[TICKS_W-1:0];
        REG_RELEASE_RATE:  cfg.release_rate  <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    case (idx)
      REG_ATTACK_LEVEL:  prdata = APB_DW'(cfg.attack_level);
      REG_DECAY_LEVEL:   prdata = APB_DW'(cfg.decay_level);
      REG_SUSTAIN_LEVEL: prdata = APB_DW'(cfg.sustain_level);
      REG_ATTACK_RATE:   prdata = APB_DW'(cfg.attack_rate);
      REG_DECAY_RATE:    prdata = APB_DW'(cfg.decay_rate);
      REG_SUSTAIN_TICKS: prdata = APB_DW'(cfg.sustain_ticks);
      REG_RELEASE_RATE:  prdata = APB_DW'(cfg.release_rate);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/adsr_div.sv
// Shared restoring divider: one quotient bit per cycle, 8-bit divisor.
// Depends on adsr_pkg for CNT_W and div_stat_t.
`default_nettype none

module adsr_div
  import adsr_pkg::*;
#(
  parameter int NUM_W = 2 * VOL_FRAC_BITS_DEF + 15
)(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [CNT_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output div_stat_t             stat
);

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den_r;
  logic [ITER_W-1:0] iter;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              ge;

  // One restoring step
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = rem_sh >= {1'b0, den_r};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      iter <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        iter      <= ITER_W'(NUM_W);
      end else if (stat.busy) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Shift numerator bits in, quotient bits out
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (stat.busy) begin
      rem <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/adsr_envelope_tick_generator.sv
// ADSR envelope tick generator: one result beat per command beat.
// Each command goes through evaluate, then the divider when a ramp step or
// note-on level needs a division, then publish; a new command is accepted
// only when idle, after the last one is published. A result beat not yet
// taken holds the next command in the publish step.
// Reset (synchronous, rst high) restores register defaults, phase off, silent.
`default_nettype none

module adsr_envelope_tick_generator
  import adsr_pkg::*;
#(
  parameter int VOL_FRAC_BITS = VOL_FRAC_BITS_DEF
)(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  adsr_cmd_if.sink               req,
  adsr_rsp_if.source             rsp
);

  localparam int LVL_W = VOL_FRAC_BITS + LVLR_W;
  localparam int NUM_W = LVL_W + CNT_W;
  localparam int CMP_W = (LVL_W > VOL_W) ? LVL_W : VOL_W;
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(LVL_CAP) << VOL_FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_PUB  = 2'd3;

  cfg_t              cfg;
  logic [1:0]        state;
  logic [PHASE_W-1:0] phase;
  logic [CNT_W-1:0]  ramp_cnt;
  logic [CNT_W-1:0]  hold_cnt;
  logic [LVL_W-1:0]  level;
  logic              sounding;
  logic [1:0]        lv_op;
  logic [CMD_W-1:0]  cmd_r;
  logic [VEL_W-1:0]  vel_r;

  logic [PHASE_W-1:0] phase_next;
  logic [CNT_W-1:0]  ramp_cnt_next;
  logic [CNT_W-1:0]  hold_cnt_next;
  logic [LVL_W-1:0]  level_next;
  logic              sounding_next;
  logic [1:0]        lv_op_next;
  logic              go_div;
  logic [LVL_W-1:0]  mul_a;
  logic [CNT_W-1:0]  mul_b;
  logic [CNT_W-1:0]  div_den;

  logic [LVL_W-1:0]  a_s, d_s, s_s;
  logic [CNT_W-1:0]  ramp1, hold1;
  logic [CNT_W-1:0]  len_a, len_d, len_r;
  logic [VEL_W-1:0]  vel_eff;
  logic [NUM_W-1:0]  product;
  logic [NUM_W-1:0]  quo;
  logic [LVL_W-1:0]  q_lvl;
  logic [LVL_W-1:0]  lvl_div;
  logic [CMP_W-1:0]  lvl_ext;
  logic              out_load;
  div_stat_t         div_stat;

  adsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Scaled targets and ramp lengths
  assign a_s     = LVL_W'(lvl_cap(cfg.attack_level)) << VOL_FRAC_BITS;
  assign d_s     = LVL_W'(lvl_cap(cfg.decay_level)) << VOL_FRAC_BITS;
  assign s_s     = LVL_W'(lvl_cap(cfg.sustain_level)) << VOL_FRAC_BITS;
  assign len_a   = ramp_len(cfg.attack_rate);
  assign len_d   = ramp_len(cfg.decay_rate);
  assign len_r   = ramp_len(cfg.release_rate);
  assign ramp1   = ramp_cnt + 1'b1;
  assign hold1   = hold_cnt + 1'b1;
  assign vel_eff = (vel_r == '0) ? VEL_DEFAULT : vel_r;

  // Decide the next envelope state for the held command
  always_comb begin
    phase_next    = phase;
    ramp_cnt_next = ramp_cnt;
    hold_cnt_next = hold_cnt;
    level_next    = level;
    sounding_next = sounding;
    lv_op_next    = LV_QUO;
    go_div        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_den       = VEL_DIVISOR;
    case (cmd_r)
      CMD_TICK: begin
        if (sounding) begin
          case (phase)
            PH_ATTACK: begin
              if (cfg.attack_rate == '0 || ramp1 >= len_a || a_s == '0) begin
                level_next    = a_s;
                phase_next    = PH_DECAY;
                ramp_cnt_next = '0;
              end else begin
                ramp_cnt_next = ramp1;
                mul_a         = a_s;
                mul_b         = ramp1;
                div_den       = len_a;
                go_div        = 1'b1;
              end
            end
            PH_DECAY: begin
              if (cfg.decay_rate == '0 || ramp1 >= len_d) begin
                level_next    = d_s;
                phase_next    = PH_SUSTAIN;
                hold_cnt_next = '0;
                ramp_cnt_next = '0;
              end else begin
                ramp_cnt_next = ramp1;
                mul_b         = ramp1;
                div_den       = len_d;
                go_div        = 1'b1;
                if (d_s >= a_s) begin
                  mul_a      = d_s - a_s;
                  lv_op_next = LV_ADD;
                end else begin
                  mul_a      = a_s - d_s;
                  lv_op_next = LV_SUB;
                end
              end
            end
            PH_SUSTAIN: begin
              level_next = s_s;
              if (cfg.sustain_ticks != '0) begin
                hold_cnt_next = hold1;
                if (hold1 >= cfg.sustain_ticks) begin
                  phase_next    = PH_RELEASE;
                  ramp_cnt_next = '0;
                end
              end
            end
            PH_RELEASE: begin
              if (cfg.release_rate == '0 || ramp1 >= len_r || s_s == '0) begin
                level_next    = '0;
                phase_next    = PH_OFF;
                sounding_next = 1'b0;
              end else begin
                ramp_cnt_next = ramp1;
                mul_a         = s_s;
                mul_b         = len_r - ramp1;
                div_den       = len_r;
                go_div        = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_NOTE_ON: begin
        sounding_next = 1'b1;
        phase_next    = PH_ATTACK;
        ramp_cnt_next = '0;
        hold_cnt_next = '0;
        if (cfg.attack_rate == '0) begin
          mul_a   = a_s;
          mul_b   = CNT_W'(vel_eff);
          div_den = VEL_DIVISOR;
          go_div  = 1'b1;
        end else begin
          level_next = '0;
        end
      end
      CMD_NOTE_OFF: begin
        if (sounding && phase != PH_OFF && phase != PH_RELEASE) begin
          phase_next    = PH_RELEASE;
          ramp_cnt_next = '0;
        end
      end
      default: ;
    endcase
  end

  // One multiply feeds the divider's numerator register
  assign product = NUM_W'(mul_a) * NUM_W'(mul_b);

  adsr_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_EVAL && go_div),
    .num   (product),
    .den   (div_den),
    .quo   (quo),
    .stat  (div_stat)
  );

  // Fold the quotient into the level
  assign q_lvl = quo[LVL_W-1:0];
  always_comb begin
    case (lv_op)
      LV_ADD:  lvl_div = a_s + q_lvl;
      LV_SUB:  lvl_div = a_s - q_lvl;
      default: lvl_div = q_lvl;
    endcase
  end

  assign out_load = (state == ST_PUB) && (!rsp.valid || rsp.ready);
  assign req.ready = (state == ST_IDLE);

  // Sequencer and envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_OFF;
      ramp_cnt  <= '0;
      hold_cnt  <= '0;
      level     <= '0;
      sounding  <= 1'b0;
      lv_op     <= LV_QUO;
      rsp.valid <= 1'b0;
    end else begin
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          phase    <= phase_next;
          ramp_cnt <= ramp_cnt_next;
          hold_cnt <= hold_cnt_next;
          level    <= level_next;
          sounding <= sounding_next;
          lv_op    <= lv_op_next;
          state    <= go_div ? ST_DIV : ST_PUB;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            level <= lvl_div;
            state <= ST_PUB;
          end
        end
        ST_PUB: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the accepted command beat
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_r <= req.cmd;
      vel_r <= req.velocity;
    end
  end

  // Drive the result beat, saturating the volume to 15 bits
  assign lvl_ext = CMP_W'(level);
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.volume    <= (lvl_ext > CMP_W'(VOL_MAX)) ? VOL_MAX : lvl_ext[VOL_W-1:0];
      rsp.env_phase <= phase;
      rsp.active    <= sounding;
    end
  end

`ifndef ASSERT_OFF
  // A silent envelope always sits in the off phase
  a_silent_off: assert property (@(posedge clk) disable iff (rst)
    !sounding |-> phase == PH_OFF)
    else $error("envelope silent outside the off phase");

  // The level never exceeds full scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_FULL)
    else $error("envelope level above full scale");

  // While waiting on the divider, it is running or just finished
  a_div_live: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_stat.busy || div_stat.done)
    else $error("sequencer waits on an idle divider");

  // A new result beat appears only from the publish step
  a_pub_only: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_PUB)
    else $error("result beat raised outside publish");
`endif

endmodule

`default_nettype wire
